### sv/olapd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olapd_pkg
// Types and codes shared by the ordered list block, its checker and its testbench.
// ----------------------------------------------------------------------------
package olapd_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } rsp_t;

endpackage
`default_nettype wire

### sv/ordered_list_append_pop_delete.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_append_pop_delete
// Bounded ordered list of 32-bit values: append, pop-front, delete-by-value.
// ----------------------------------------------------------------------------
// Entries sit in one circular RAM addressed from a head pointer. A request is
// taken when start is high and busy is low; its result shows on rsp for one
// cycle with done high, and must be taken then. Append, pop and the unused
// request code give their result the cycle after the request and the block is
// ready again at once (one request per cycle). Delete walks the RAM from the
// head, one entry per cycle, then moves every later entry down one slot, one
// per cycle through the single write port, and a miss ends after the last
// entry is compared.
// ----------------------------------------------------------------------------
module ordered_list_append_pop_delete #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  olapd_pkg::req_t  req,
  output logic             done,
  output olapd_pkg::rsp_t  rsp
);

  import olapd_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW+1:0] CAP_S = (CW+2)'(CAPACITY);
  localparam logic [PW-1:0] LAST_P = PW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [PW-1:0]       head, head_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       idx, idx_next;
  logic [VALUE_W-1:0]  key, key_next;
  logic                done_next;
  rsp_t                rsp_next;

  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [PW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;
  logic [CW:0]         rd_off;
  logic [CW:0]         idx_x;
  logic [CW:0]         cnt_x;

  // logical offset from the head to a physical slot
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW:0] off);
    logic [CW+1:0] s;
    s = (CW+2)'(h) + (CW+2)'(off);
    if (s >= CAP_S) s = s - CAP_S;
    if (s >= CAP_S) s = s - CAP_S;
    return s[PW-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] cnt5(input logic [CW-1:0] c);
    logic [CW+COUNT_W-1:0] t;
    t = (CW+COUNT_W)'(c);
    return t[COUNT_W-1:0];
  endfunction

  assign busy  = (state != S_IDLE);
  assign idx_x = {1'b0, idx};
  assign cnt_x = {1'b0, cnt};
  assign ram_raddr = phys(head, rd_off);

  always_comb begin
    state_next = state;
    head_next  = head;
    cnt_next   = cnt;
    idx_next   = idx;
    key_next   = key;
    done_next  = 1'b0;
    rsp_next   = rsp;
    ram_we     = 1'b0;
    ram_waddr  = phys(head, cnt_x);
    ram_wdata  = req.value;
    rd_off     = '0;
    case (state)
      S_IDLE: begin
        rd_off = '0;
        if (start) begin
          key_next = req.value;
          case (req.req_type)
            REQ_APPEND: begin
              done_next = 1'b1;
              if (cnt == CAP_C) begin
                rsp_next = '{status: ST_FULL, count: cnt5(cnt)};
              end else begin
                ram_we   = 1'b1;
                cnt_next = cnt + 1'b1;
                rsp_next = '{status: ST_OK, count: cnt5(cnt + 1'b1)};
              end
            end
            REQ_POP: begin
              done_next = 1'b1;
              if (cnt == '0) begin
                rsp_next = '{status: ST_EMPTY, count: cnt5(cnt)};
              end else begin
                head_next = (head == LAST_P) ? '0 : head + 1'b1;
                cnt_next  = cnt - 1'b1;
                rsp_next  = '{status: ST_OK, count: cnt5(cnt - 1'b1)};
              end
            end
            REQ_DELETE: begin
              if (cnt == '0) begin
                done_next = 1'b1;
                rsp_next  = '{status: ST_NOT_FOUND, count: cnt5(cnt)};
              end else begin
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
              rsp_next  = '{status: ST_OK, count: cnt5(cnt)};
            end
          endcase
        end
      end
      S_SCAN: begin
        // rdata holds entry idx; fetch idx+1 for the next compare or the shift
        rd_off = idx_x + 1'b1;
        if (ram_rdata == key) begin
          state_next = S_SHIFT;
        end else if ((idx_x + 1'b1) == cnt_x) begin
          done_next  = 1'b1;
          rsp_next   = '{status: ST_NOT_FOUND, count: cnt5(cnt)};
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_SHIFT: begin
        // rdata holds entry idx+1, which moves down into slot idx
        rd_off = idx_x + 2'd2;
        if ((idx_x + 1'b1) < cnt_x) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head, idx_x);
          ram_wdata = ram_rdata;
          idx_next  = idx + 1'b1;
        end else begin
          cnt_next   = cnt - 1'b1;
          done_next  = 1'b1;
          rsp_next   = '{status: ST_OK, count: cnt5(cnt - 1'b1)};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    key <= key_next;
    rsp <= rsp_next;
  end

  olapd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

### sv/olapd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olapd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module olapd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### verif/olapd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olapd_result_checker
// Watches the request and result channels of the ordered list, keeps a shadow
// copy of the list contents, predicts status and count for every accepted
// request and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module olapd_result_checker
  import olapd_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  logic [VALUE_W-1:0] list_vals[$];
  rsp_t               expected_rsps[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // applies one request to the shadow list and returns the result it should give
  function automatic rsp_t apply_list_request(input req_t r);
    rsp_t res;
    int   hit;
    res.status = ST_OK;
    hit = -1;
    case (r.req_type)
      REQ_APPEND: begin
        if (list_vals.size() >= CAPACITY) res.status = ST_FULL;
        else list_vals.push_back(r.value);
      end
      REQ_POP: begin
        if (list_vals.size() == 0) res.status = ST_EMPTY;
        else void'(list_vals.pop_front());
      end
      REQ_DELETE: begin
        // first match from the head wins
        for (int i = 0; i < list_vals.size(); i++)
          if (hit < 0 && list_vals[i] == r.value) hit = i;
        if (hit < 0) res.status = ST_NOT_FOUND;
        else list_vals.delete(hit);
      end
      default: ;
    endcase
    res.count = COUNT_W'(list_vals.size());
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      list_vals.delete();
      expected_rsps.delete();
    end else begin
      // a result beat never belongs to a request taken at the same edge
      if (done) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding (status %0d count %0d)",
                                    rsp.status, rsp.count));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", rsp.count, want.count));
        end
      end
      if (start && !busy) expected_rsps.push_back(apply_list_request(req));
    end
    pending = expected_rsps.size();
  end

endmodule

### verif/ordered_list_append_pop_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_pop_delete_tb
// Drives append, pop and delete requests into the ordered list: a directed
// run through the corner cases, then random traffic that swings between
// filling and draining the list, with values mostly from a small pool so
// deletes hit often. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module ordered_list_append_pop_delete_tb;
  import olapd_pkg::*;

  localparam int         CAPACITY         = 16;
  localparam logic [1:0] REQ_UNUSED       = 2'd3;
  localparam int         RANDOM_PER_PHASE = 212;
  localparam int         SEGMENT_LEN      = 24;
  localparam int         DRAIN_CYCLES     = 40;
  localparam int         WATCHDOG_LIMIT   = 2000;

  localparam logic [31:0] V_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] V_MIN  = 32'h8000_0000;
  localparam logic [31:0] V_ZERO = 32'h0000_0000;
  localparam logic [31:0] V_ONES = 32'hFFFF_FFFF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  int          errors;
  int          pending;
  int          sender_idle_pct;
  int          idle_cycles;
  logic [31:0] value_pool[8];

  ordered_list_append_pop_delete #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  olapd_result_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .rsp    (rsp),
    .errors (errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ends the run when neither a request nor a result moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic issue_request(input logic [1:0] kind, input logic [31:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      req   <= '{req_type: 2'($urandom), value: $urandom};
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{req_type: kind, value: val};
    do @(posedge clk); while (busy);
  endtask

  task automatic draw_request(input int append_pct, output logic [1:0] kind,
                              output logic [31:0] val);
    if ($urandom_range(99) < 4) kind = REQ_UNUSED;
    else if ($urandom_range(99) < append_pct) kind = REQ_APPEND;
    else if ($urandom_range(99) < 60) kind = REQ_DELETE;
    else kind = REQ_POP;
    // pool values make duplicates and delete hits common
    if ($urandom_range(99) < 65) val = value_pool[$urandom_range(7)];
    else val = $urandom;
  endtask

  initial begin
    logic [1:0]  kind;
    logic [31:0] val;
    int          append_pct;
    rst             = 1'b1;
    start           = 1'b0;
    req             = '0;
    idle_cycles     = 0;
    append_pct      = 100;
    sender_idle_pct = 16;
    value_pool[0]   = V_MAX;
    value_pool[1]   = V_MIN;
    value_pool[2]   = V_ZERO;
    value_pool[3]   = V_ONES;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // corner cases on an empty and a short list
    issue_request(REQ_POP, V_ZERO);
    issue_request(REQ_DELETE, V_ONES);
    issue_request(REQ_UNUSED, V_MIN);
    issue_request(REQ_APPEND, V_MAX);
    issue_request(REQ_APPEND, V_MIN);
    issue_request(REQ_APPEND, V_ZERO);
    issue_request(REQ_APPEND, V_ONES);
    issue_request(REQ_APPEND, V_MIN);
    issue_request(REQ_DELETE, V_MIN);
    issue_request(REQ_DELETE, 32'h0000_0001);
    issue_request(REQ_DELETE, V_ONES);
    issue_request(REQ_DELETE, V_MAX);
    issue_request(REQ_UNUSED, V_ONES);
    issue_request(REQ_POP, V_ONES);
    issue_request(REQ_POP, V_MAX);
    issue_request(REQ_POP, V_MIN);

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 55 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // the first segment of the first phase fills the list to hit the full case
        if (n % SEGMENT_LEN == 0 && !(ph == 0 && n == 0)) begin
          case ($urandom_range(2))
            0:       append_pct = 80;
            1:       append_pct = 20;
            default: append_pct = 50;
          endcase
        end
        draw_request(append_pct, kind, val);
        issue_request(kind, val);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
sv/olapd_pkg.sv
sv/olapd_ram.sv
sv/ordered_list_append_pop_delete.sv
verif/olapd_result_checker.sv
verif/ordered_list_append_pop_delete_tb.sv
